/* src/x86_byte_stream_instruction_decoder_defines.svh */
// assertion macros for the x86 byte stream decoder
`ifndef X86_BYTE_STREAM_INSTRUCTION_DECODER_DEFINES_SVH
`define X86_BYTE_STREAM_INSTRUCTION_DECODER_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define X86BD_ASSERT_NOW(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("x86bd same-cycle check failed");

// condition must hold in the cycle after the trigger
`define X86BD_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("x86bd next-cycle check failed");

`endif

/* src/x86bd_pkg.sv */
// shared types, codes and decode helpers for the x86 byte stream decoder
package x86bd_pkg;

   localparam logic [1:0] OP_MOV = 2'd0;
   localparam logic [1:0] OP_ADD = 2'd1;
   localparam logic [1:0] OP_SUB = 2'd2;
   localparam logic [1:0] OP_CMP = 2'd3;

   localparam logic [1:0] DISP_NONE   = 2'd0;
   localparam logic [1:0] DISP_8      = 2'd1;
   localparam logic [1:0] DISP_16     = 2'd2;
   localparam logic [1:0] DISP_DIRECT = 2'd3;

   localparam logic [1:0] MOD_NO_DISP = 2'd0;
   localparam logic [1:0] MOD_DISP8   = 2'd1;
   localparam logic [1:0] MOD_DISP16  = 2'd2;

   localparam logic [2:0] RM_DIRECT = 3'd6;

   localparam logic       STATUS_OK      = 1'b0;
   localparam logic       STATUS_UNKNOWN = 1'b1;
   localparam logic       FORM_IMM       = 1'b0;
   localparam logic       FORM_REGMEM    = 1'b1;

   // opcode groups, keyed on the upper six bits (mov immediate on the upper four)
   localparam logic [3:0] OPC_MOV_IMM = 4'hB;
   localparam logic [5:0] GRP_ADD     = 6'h00;
   localparam logic [5:0] GRP_MOV     = 6'h22;
   localparam logic [5:0] GRP_SUB     = 6'h0A;
   localparam logic [5:0] GRP_CMP     = 6'h0E;

   typedef enum logic [5:0] {
      PH_OPCODE  = 6'b000001,
      PH_IMM_LO  = 6'b000010,
      PH_IMM_HI  = 6'b000100,
      PH_MODRM   = 6'b001000,
      PH_DISP_LO = 6'b010000,
      PH_DISP_HI = 6'b100000
   } phase_type;

   typedef struct packed {
      logic        status;
      logic [1:0]  operation;
      logic        form;
      logic        reg_is_destination;
      logic        wide;
      logic [1:0]  addr_mode;
      logic [2:0]  reg_field;
      logic [2:0]  rm_field;
      logic [1:0]  disp_kind;
      logic [15:0] displacement;
      logic [15:0] immediate;
   } result_type;

   // bit 2 flags a register/memory opcode, bits 1:0 give its operation
   function automatic logic [2:0] regmem_op(input logic [7:0] opc);
      logic [2:0] r;
      unique case (opc[7:2])
         GRP_ADD: r = {1'b1, OP_ADD};
         GRP_MOV: r = {1'b1, OP_MOV};
         GRP_SUB: r = {1'b1, OP_SUB};
         GRP_CMP: r = {1'b1, OP_CMP};
         default: r = 3'b000;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] disp_kind_of(input logic [7:0] modrm);
      logic [1:0] k;
      unique case (modrm[7:6])
         MOD_DISP8:   k = DISP_8;
         MOD_DISP16:  k = DISP_16;
         MOD_NO_DISP: k = (modrm[2:0] == RM_DIRECT) ? DISP_DIRECT : DISP_NONE;
         default:     k = DISP_NONE;
      endcase
      return k;
   endfunction

   function automatic result_type imm_result(input logic [7:0] opc, input logic [15:0] data);
      result_type r;
      r                    = '0;
      r.status             = STATUS_OK;
      r.operation          = OP_MOV;
      r.form               = FORM_IMM;
      r.reg_is_destination = 1'b1;
      r.wide               = opc[3];
      r.reg_field          = opc[2:0];
      r.immediate          = data;
      return r;
   endfunction

   function automatic result_type regmem_result(input logic [7:0] opc, input logic [7:0] modrm,
                                                input logic [1:0] kind, input logic [15:0] disp);
      result_type r;
      logic [2:0] op;
      r                    = '0;
      op                   = regmem_op(opc);
      r.status             = STATUS_OK;
      r.operation          = op[1:0];
      r.form               = FORM_REGMEM;
      r.reg_is_destination = opc[1];
      r.wide               = opc[0];
      r.addr_mode          = modrm[7:6];
      r.reg_field          = modrm[5:3];
      r.rm_field           = modrm[2:0];
      r.disp_kind          = kind;
      r.displacement       = disp;
      return r;
   endfunction

endpackage

/* src/x86bd_in_stage.sv */
// input register for the byte stream, stalls upstream while a byte is held back
module x86bd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_in,
   input  logic       consume,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       take;

   assign req_stall = valid_ff && !consume;
   assign take      = req_valid && !req_stall;

   always_comb begin
      priority if (take) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_byte_in;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

/* src/x86bd_decode.sv */
// phase machine that walks the instruction bytes and builds the decoded result
module x86bd_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   consume,
   input  logic [7:0]             byte_data,
   output logic                   emit,
   output x86bd_pkg::result_type  result
);

   x86bd_pkg::phase_type phase_ff, phase_in;
   logic [7:0] opcode_ff, opcode_in;
   logic [7:0] modrm_ff, modrm_in;
   logic [7:0] low_ff, low_in;
   logic [2:0] grp;
   logic [1:0] kind_new, kind_held;

   assign grp       = x86bd_pkg::regmem_op(byte_data);
   assign kind_new  = x86bd_pkg::disp_kind_of(byte_data);
   assign kind_held = x86bd_pkg::disp_kind_of(modrm_ff);

   always_comb begin
      phase_in  = x86bd_pkg::PH_OPCODE;
      opcode_in = opcode_ff;
      modrm_in  = modrm_ff;
      low_in    = low_ff;
      emit      = 1'b0;
      result    = '0;
      unique case (phase_ff)
         x86bd_pkg::PH_IMM_LO: begin
            if (opcode_ff[3]) begin
               low_in   = byte_data;
               phase_in = x86bd_pkg::PH_IMM_HI;
            end else begin
               emit   = 1'b1;
               result = x86bd_pkg::imm_result(opcode_ff, {8'h00, byte_data});
            end
         end
         x86bd_pkg::PH_IMM_HI: begin
            emit   = 1'b1;
            result = x86bd_pkg::imm_result(opcode_ff, {byte_data, low_ff});
         end
         x86bd_pkg::PH_MODRM: begin
            modrm_in = byte_data;
            if (kind_new == x86bd_pkg::DISP_NONE) begin
               emit   = 1'b1;
               result = x86bd_pkg::regmem_result(opcode_ff, byte_data,
                                                 x86bd_pkg::DISP_NONE, 16'h0000);
            end else begin
               phase_in = x86bd_pkg::PH_DISP_LO;
            end
         end
         x86bd_pkg::PH_DISP_LO: begin
            if (kind_held == x86bd_pkg::DISP_8) begin
               emit   = 1'b1;
               result = x86bd_pkg::regmem_result(opcode_ff, modrm_ff,
                                                 x86bd_pkg::DISP_8, {8'h00, byte_data});
            end else begin
               low_in   = byte_data;
               phase_in = x86bd_pkg::PH_DISP_HI;
            end
         end
         x86bd_pkg::PH_DISP_HI: begin
            emit   = 1'b1;
            result = x86bd_pkg::regmem_result(opcode_ff, modrm_ff, kind_held,
                                              {byte_data, low_ff});
         end
         default: begin
            // opcode byte
            priority if (byte_data[7:4] == x86bd_pkg::OPC_MOV_IMM) begin
               opcode_in = byte_data;
               phase_in  = x86bd_pkg::PH_IMM_LO;
            end else if (grp[2]) begin
               opcode_in = byte_data;
               phase_in  = x86bd_pkg::PH_MODRM;
            end else begin
               emit          = 1'b1;
               result.status = x86bd_pkg::STATUS_UNKNOWN;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= x86bd_pkg::PH_OPCODE;
      end else if (consume) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consume) begin
         opcode_ff <= opcode_in;
         modrm_ff  <= modrm_in;
         low_ff    <= low_in;
      end
   end

endmodule

/* src/x86bd_out_stage.sv */
// result register that holds a decoded word until downstream takes it
module x86bd_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  x86bd_pkg::result_type result,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output x86bd_pkg::result_type rsp
);

   logic                  valid_ff, valid_in;
   x86bd_pkg::result_type rsp_ff;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* src/x86_byte_stream_instruction_decoder.sv */
// top level of the x86 byte stream instruction decoder
// Decodes a 16-bit x86 byte stream, one byte per accepted word, for mov immediate to
// register and add/mov/sub/cmp register-memory with register. Each byte is registered
// in the input stage and then passes the phase machine; the result of the instruction's
// last byte is registered in the output stage before it appears on the rsp side. A new
// byte is taken every cycle; only a stalled result register holds back a byte that
// would produce another result. An unknown opcode byte gives a result with status set
// and all other fields zero, and decoding resumes with the next byte as an opcode.
`include "x86_byte_stream_instruction_decoder_defines.svh"

module x86_byte_stream_instruction_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [1:0]  rsp_operation,
   output logic        rsp_form,
   output logic        rsp_reg_is_destination,
   output logic        rsp_wide,
   output logic [1:0]  rsp_addr_mode,
   output logic [2:0]  rsp_reg_field,
   output logic [2:0]  rsp_rm_field,
   output logic [1:0]  rsp_disp_kind,
   output logic [15:0] rsp_displacement,
   output logic [15:0] rsp_immediate
);

   logic                  byte_valid;
   logic [7:0]            byte_data;
   logic                  consume;
   logic                  emit;
   logic                  out_free;
   x86bd_pkg::result_type result;
   x86bd_pkg::result_type rsp;
   logic                  unknown_blank;
   logic                  imm_fields_ok;

   // a byte that yields no result can move on even when the output is full
   assign consume = byte_valid && (!emit || out_free);

   x86bd_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_byte_in (req_byte_in),
      .consume     (consume),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   x86bd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .consume   (consume),
      .byte_data (byte_data),
      .emit      (emit),
      .result    (result)
   );

   x86bd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (consume && emit),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_status             = rsp.status;
   assign rsp_operation          = rsp.operation;
   assign rsp_form               = rsp.form;
   assign rsp_reg_is_destination = rsp.reg_is_destination;
   assign rsp_wide               = rsp.wide;
   assign rsp_addr_mode          = rsp.addr_mode;
   assign rsp_reg_field          = rsp.reg_field;
   assign rsp_rm_field           = rsp.rm_field;
   assign rsp_disp_kind          = rsp.disp_kind;
   assign rsp_displacement       = rsp.displacement;
   assign rsp_immediate          = rsp.immediate;

   assign unknown_blank = (rsp_operation == x86bd_pkg::OP_MOV)
                          && (rsp_form == x86bd_pkg::FORM_IMM)
                          && (rsp_displacement == 16'h0000)
                          && (rsp_immediate == 16'h0000);
   assign imm_fields_ok = rsp_reg_is_destination
                          && (rsp_disp_kind == x86bd_pkg::DISP_NONE)
                          && (rsp_displacement == 16'h0000);

   `X86BD_ASSERT_NOW(a_stall_only_when_held, req_stall, byte_valid && emit && !out_free)
   `X86BD_ASSERT_NEXT(a_emit_reaches_output, consume && emit, rsp_valid)
   `X86BD_ASSERT_NOW(a_unknown_is_blank, rsp_valid && rsp_status, unknown_blank)
   `X86BD_ASSERT_NOW(a_imm_form_fields, rsp_valid && !rsp_status && !rsp_form, imm_fields_ok)

endmodule

/* dv/tb_x86_byte_stream_instruction_decoder.sv */
// testbench for the x86 byte stream instruction decoder: directed and random byte streams
`timescale 1ns / 100ps

module tb_x86_byte_stream_instruction_decoder;

   localparam int CYCLE_LIMIT      = 600000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 8;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_status;
   logic [1:0]  rsp_operation;
   logic        rsp_form;
   logic        rsp_reg_is_destination;
   logic        rsp_wide;
   logic [1:0]  rsp_addr_mode;
   logic [2:0]  rsp_reg_field;
   logic [2:0]  rsp_rm_field;
   logic [1:0]  rsp_disp_kind;
   logic [15:0] rsp_displacement;
   logic [15:0] rsp_immediate;

   x86_byte_stream_instruction_decoder uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_byte_in            (req_byte_in),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_operation          (rsp_operation),
      .rsp_form               (rsp_form),
      .rsp_reg_is_destination (rsp_reg_is_destination),
      .rsp_wide               (rsp_wide),
      .rsp_addr_mode          (rsp_addr_mode),
      .rsp_reg_field          (rsp_reg_field),
      .rsp_rm_field           (rsp_rm_field),
      .rsp_disp_kind          (rsp_disp_kind),
      .rsp_displacement       (rsp_displacement),
      .rsp_immediate          (rsp_immediate)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   int                    errors = 0;
   int                    cycles = 0;
   int                    bytes_sent = 0;
   bit                    gaps_enable = 1'b0;
   bit                    stall_enable = 1'b0;
   bit                    long_hold_req = 1'b0;
   int                    stall_left = 0;
   x86bd_pkg::result_type pending_decodes[$];

   // decoder shadow state
   x86bd_pkg::phase_type  dec_phase = x86bd_pkg::PH_OPCODE;
   logic [7:0]            held_opcode = 8'h00;
   logic [7:0]            held_modrm = 8'h00;
   logic [7:0]            held_low = 8'h00;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // operation of a register/memory opcode
   function automatic logic [1:0] group_operation(input logic [7:0] opc);
      if (opc[7:2] == x86bd_pkg::GRP_ADD) return x86bd_pkg::OP_ADD;
      if (opc[7:2] == x86bd_pkg::GRP_SUB) return x86bd_pkg::OP_SUB;
      if (opc[7:2] == x86bd_pkg::GRP_CMP) return x86bd_pkg::OP_CMP;
      return x86bd_pkg::OP_MOV;
   endfunction

   function automatic bit is_group_opcode(input logic [7:0] opc);
      return (opc[7:2] == x86bd_pkg::GRP_ADD) || (opc[7:2] == x86bd_pkg::GRP_MOV)
             || (opc[7:2] == x86bd_pkg::GRP_SUB) || (opc[7:2] == x86bd_pkg::GRP_CMP);
   endfunction

   function automatic logic [1:0] modrm_disp(input logic [7:0] m);
      if (m[7:6] == x86bd_pkg::MOD_DISP8) return x86bd_pkg::DISP_8;
      if (m[7:6] == x86bd_pkg::MOD_DISP16) return x86bd_pkg::DISP_16;
      if (m[7:6] == x86bd_pkg::MOD_NO_DISP && m[2:0] == x86bd_pkg::RM_DIRECT) begin
         return x86bd_pkg::DISP_DIRECT;
      end
      return x86bd_pkg::DISP_NONE;
   endfunction

   function automatic x86bd_pkg::result_type make_imm(input logic [15:0] data);
      x86bd_pkg::result_type r;
      r = '0;
      r.status = x86bd_pkg::STATUS_OK;
      r.operation = x86bd_pkg::OP_MOV;
      r.form = x86bd_pkg::FORM_IMM;
      r.reg_is_destination = 1'b1;
      r.wide = held_opcode[3];
      r.reg_field = held_opcode[2:0];
      r.immediate = data;
      return r;
   endfunction

   function automatic x86bd_pkg::result_type make_regmem(input logic [1:0] kind,
                                                         input logic [15:0] disp);
      x86bd_pkg::result_type r;
      r = '0;
      r.status = x86bd_pkg::STATUS_OK;
      r.operation = group_operation(held_opcode);
      r.form = x86bd_pkg::FORM_REGMEM;
      r.reg_is_destination = held_opcode[1];
      r.wide = held_opcode[0];
      r.addr_mode = held_modrm[7:6];
      r.reg_field = held_modrm[5:3];
      r.rm_field = held_modrm[2:0];
      r.disp_kind = kind;
      r.displacement = disp;
      return r;
   endfunction

   // advance the shadow phase machine by one accepted byte
   task automatic decode_byte(input logic [7:0] b);
      x86bd_pkg::result_type r;
      case (dec_phase)
         x86bd_pkg::PH_IMM_LO: begin
            if (held_opcode[3]) begin
               held_low = b;
               dec_phase = x86bd_pkg::PH_IMM_HI;
            end else begin
               pending_decodes.push_back(make_imm({8'h00, b}));
               dec_phase = x86bd_pkg::PH_OPCODE;
            end
         end
         x86bd_pkg::PH_IMM_HI: begin
            pending_decodes.push_back(make_imm({b, held_low}));
            dec_phase = x86bd_pkg::PH_OPCODE;
         end
         x86bd_pkg::PH_MODRM: begin
            held_modrm = b;
            if (modrm_disp(b) == x86bd_pkg::DISP_NONE) begin
               pending_decodes.push_back(make_regmem(x86bd_pkg::DISP_NONE, 16'h0000));
               dec_phase = x86bd_pkg::PH_OPCODE;
            end else begin
               dec_phase = x86bd_pkg::PH_DISP_LO;
            end
         end
         x86bd_pkg::PH_DISP_LO: begin
            if (modrm_disp(held_modrm) == x86bd_pkg::DISP_8) begin
               pending_decodes.push_back(make_regmem(x86bd_pkg::DISP_8, {8'h00, b}));
               dec_phase = x86bd_pkg::PH_OPCODE;
            end else begin
               held_low = b;
               dec_phase = x86bd_pkg::PH_DISP_HI;
            end
         end
         x86bd_pkg::PH_DISP_HI: begin
            pending_decodes.push_back(make_regmem(modrm_disp(held_modrm), {b, held_low}));
            dec_phase = x86bd_pkg::PH_OPCODE;
         end
         default: begin
            if (b[7:4] == x86bd_pkg::OPC_MOV_IMM) begin
               held_opcode = b;
               dec_phase = x86bd_pkg::PH_IMM_LO;
            end else if (is_group_opcode(b)) begin
               held_opcode = b;
               dec_phase = x86bd_pkg::PH_MODRM;
            end else begin
               r = '0;
               r.status = x86bd_pkg::STATUS_UNKNOWN;
               pending_decodes.push_back(r);
               dec_phase = x86bd_pkg::PH_OPCODE;
            end
         end
      endcase
   endtask

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_byte(input logic [7:0] b);
      int   gap;
      logic taken;
      gap = gaps_enable ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
         if (taken) decode_byte(b);
         @(negedge clock);
      end
      bytes_sent++;
   endtask

   task automatic send_random_instruction();
      int         pick;
      int         extra;
      logic [7:0] opc;
      logic [7:0] modrm;
      logic [5:0] grp;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         opc = {x86bd_pkg::OPC_MOV_IMM, 4'($urandom_range(0, 15))};
         send_byte(opc);
         send_byte(8'($urandom));
         if (opc[3]) send_byte(8'($urandom));
      end else if (pick < 85) begin
         case ($urandom_range(0, 3))
            0: grp = x86bd_pkg::GRP_ADD;
            1: grp = x86bd_pkg::GRP_MOV;
            2: grp = x86bd_pkg::GRP_SUB;
            default: grp = x86bd_pkg::GRP_CMP;
         endcase
         opc = {grp, 2'($urandom_range(0, 3))};
         modrm = 8'($urandom);
         // direct addressing is rare in uniform modrm values
         if ($urandom_range(0, 7) == 0) begin
            modrm = {x86bd_pkg::MOD_NO_DISP, 3'($urandom_range(0, 7)), x86bd_pkg::RM_DIRECT};
         end
         send_byte(opc);
         send_byte(modrm);
         case (modrm_disp(modrm))
            x86bd_pkg::DISP_8: extra = 1;
            x86bd_pkg::DISP_16, x86bd_pkg::DISP_DIRECT: extra = 2;
            default: extra = 0;
         endcase
         repeat (extra) send_byte(8'($urandom));
      end else begin
         // noise: any byte, possibly cutting into the next instruction
         send_byte(8'($urandom));
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      x86bd_pkg::result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_decodes.size() == 0) begin
            $display("%0t: unexpected result, expected none actual status %0h", $time,
                     rsp_status);
            errors++;
         end else begin
            want = pending_decodes.pop_front();
            check_field("status", 16'(want.status), 16'(rsp_status));
            check_field("operation", 16'(want.operation), 16'(rsp_operation));
            check_field("form", 16'(want.form), 16'(rsp_form));
            check_field("reg_is_destination", 16'(want.reg_is_destination),
                        16'(rsp_reg_is_destination));
            check_field("wide", 16'(want.wide), 16'(rsp_wide));
            check_field("addr_mode", 16'(want.addr_mode), 16'(rsp_addr_mode));
            check_field("reg_field", 16'(want.reg_field), 16'(rsp_reg_field));
            check_field("rm_field", 16'(want.rm_field), 16'(rsp_rm_field));
            check_field("disp_kind", 16'(want.disp_kind), 16'(rsp_disp_kind));
            check_field("displacement", want.displacement, rsp_displacement);
            check_field("immediate", want.immediate, rsp_immediate);
         end
      end
   end

   // receiver hold-off, counted in cycles
   always @(negedge clock) begin
      if (reset) begin
         stall_left = 0;
      end else if (stall_left == 0) begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD_CYCLES;
         end else if (stall_enable && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
      end else begin
         stall_left--;
      end
      rsp_stall <= (stall_left != 0);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("status: fail");
         $finish;
      end
   end

   task automatic test_directed();
      logic [7:0] stream[$];
      gaps_enable = 1'b0;
      stall_enable = 1'b0;
      stream = {8'hB0, 8'h00,                 // mov byte immediate, zero data
                8'hBF, 8'hFF, 8'hFF,          // mov word immediate, all ones
                8'h00, 8'hC0,                 // add, register mode
                8'h8B, 8'h06, 8'h34, 8'h12,   // mov, direct address
                8'h2B, 8'h47, 8'h80,          // sub, 8-bit displacement
                8'h3B, 8'h97, 8'hCD, 8'hAB,   // cmp, 16-bit displacement
                8'h01, 8'h00,                 // add, memory without displacement
                8'hC4, 8'hC7, 8'hFF};         // unknown opcodes
      foreach (stream[i]) send_byte(stream[i]);
   endtask

   task automatic test_random_stream(input int target);
      gaps_enable = 1'b1;
      stall_enable = 1'b1;
      while (bytes_sent < target) send_random_instruction();
   endtask

   task automatic test_back_to_back(input int target);
      gaps_enable = 1'b0;
      stall_enable = 1'b0;
      while (bytes_sent < target) send_random_instruction();
   endtask

   task automatic test_backpressure(input int target);
      gaps_enable = 1'b0;
      stall_enable = 1'b0;
      long_hold_req = 1'b1;
      while (bytes_sent < target) send_random_instruction();
      stall_enable = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random_stream(900);
      test_back_to_back(1200);
      test_backpressure(1450);
      test_random_stream(1770);
      req_valid <= 1'b0;
      stall_enable = 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/x86bd_pkg.sv
src/x86bd_in_stage.sv
src/x86bd_decode.sv
src/x86bd_out_stage.sv
src/x86_byte_stream_instruction_decoder.sv
dv/tb_x86_byte_stream_instruction_decoder.sv
